### hw/rtl/todat_pkg.sv
// ----------------------------------------------------------------------------
// todat_pkg
// Shared types and constants of the time-of-day alarm table: payload
// structs, action and register codes, and the clock advance handshake.
// ----------------------------------------------------------------------------
package todat_pkg;

	// Default number of alarm slots
	localparam int unsigned DEF_ALARM_SLOTS = 16;

	// One day in 2^-16 hour units, and related limits
	localparam logic [20:0] DAY_UNITS_21 = 21'd1572864;
	localparam logic [21:0] DAY_UNITS_22 = 22'd1572864;
	localparam logic [21:0] TWO_DAYS_22  = 22'd3145728;
	localparam logic [20:0] DAY_MAX      = 21'd1572863;

	// Register reset values; the rate also stands in for a rate of zero
	localparam logic [31:0] DEFAULT_RATE    = 32'd4294967;
	localparam logic [20:0] DAY_START_RST   = 21'd393216;
	localparam logic [20:0] NIGHT_START_RST = 21'd1179648;

	// Action codes
	localparam logic [1:0] ACT_TICK = 2'd0;
	localparam logic [1:0] ACT_ADD  = 2'd1;
	localparam logic [1:0] ACT_SET  = 2'd2;

	// Configuration register indexes
	localparam logic [1:0] CFG_RATE        = 2'd0;
	localparam logic [1:0] CFG_DAY_START   = 2'd1;
	localparam logic [1:0] CFG_NIGHT_START = 2'd2;

	typedef struct packed {
		logic [1:0]  action;
		logic [15:0] elapsed_ms;
		logic [15:0] alarm_id;
		logic [21:0] hour_value;
		logic        repeat_flag;
	} in_t;

	typedef struct packed {
		logic        fired_valid;
		logic [15:0] fired_id;
		logic [20:0] clock_hour;
		logic        is_day;
		logic        table_full;
		logic        last;
	} out_t;

	// One alarm slot
	typedef struct packed {
		logic [15:0] id;
		logic [20:0] hour;
		logic        rep;
	} entry_t;

	// Clock advance request and response
	typedef struct packed {
		logic        start;
		logic [20:0] old_clock;
		logic [15:0] elapsed;
		logic [31:0] rate;
	} adv_req_t;

	typedef struct packed {
		logic        done;
		logic [20:0] new_clock;
		logic        wrap;
	} adv_rsp_t;

endpackage

### hw/rtl/todat_advance.sv
// ----------------------------------------------------------------------------
// todat_advance
// Two-stage clock advance: multiply elapsed time by the rate, then scale,
// clamp below one day, add to the old clock and wrap once past midnight.
// ----------------------------------------------------------------------------
module todat_advance (
	input  logic               clk,
	input  logic               arst_n,
	input  todat_pkg::adv_req_t req,
	output todat_pkg::adv_rsp_t rsp
);
	import todat_pkg::*;

	logic        v_s1;
	logic [47:0] prod_s1;
	logic [20:0] old_s1;
	logic [31:0] rate_eff;
	logic [31:0] adv_raw;
	logic [20:0] adv_clamped;
	logic [21:0] sum;
	logic [20:0] new_clock;
	logic        done_s2;
	logic [20:0] new_s2;
	logic        wrap_s2;

	// Substitute the default rate for zero
	assign rate_eff = (req.rate == 32'd0) ? DEFAULT_RATE : req.rate;

	// Scale, clamp, add and wrap
	always_comb begin
		adv_raw     = prod_s1[47:16];
		adv_clamped = (adv_raw > {11'd0, DAY_MAX}) ? DAY_MAX : adv_raw[20:0];
		sum         = {1'b0, old_s1} + {1'b0, adv_clamped};
		new_clock   = (sum >= DAY_UNITS_22) ? 21'(sum - DAY_UNITS_22) : sum[20:0];
	end

	// Stage registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			done_s2 <= 1'b0;
		end else begin
			v_s1    <= req.start;
			done_s2 <= v_s1;
		end
	end

	// Payload of both stages
	always_ff @(posedge clk) begin
		if (req.start) begin
			prod_s1 <= 48'(req.elapsed) * 48'(rate_eff);
			old_s1  <= req.old_clock;
		end
		if (v_s1) begin
			new_s2  <= new_clock;
			wrap_s2 <= (new_clock < old_s1);
		end
	end

	assign rsp.done      = done_s2;
	assign rsp.new_clock = new_s2;
	assign rsp.wrap      = wrap_s2;

endmodule

### hw/rtl/time_of_day_alarm_table.sv
// ----------------------------------------------------------------------------
// time_of_day_alarm_table
// 24-hour clock in 2^-16 hour units with an ordered table of alarms.
// ----------------------------------------------------------------------------
// Input items arrive on in_valid/in_ready/in_data, results leave on
// out_valid/out_ready/out_data; every input gives one or more results and
// the final one carries last. The configuration port writes the rate and the
// day window on cfg_we; it is meant to be written only while the block idles.
// One item is handled at a time; in_ready is high only when idle.
// An add, a set or an unused action is accepted in idle and places its
// status result from the response state. A tick goes to the two-stage
// advance multiplier, then to a scan that reads one alarm slot per cycle
// while the output does not stall it, from the table memory (registered
// read), writing kept alarms back compacted, then to a finish state that
// places the final result.
// Fired alarms are delayed by one so that the last of them can carry last.
// A stalled receiver holds the output register and pauses the scan when a
// second fired result would need it; the input side waits meanwhile.
// Reset clears the clock, the alarm count and the registers to their
// defaults; table contents are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
module time_of_day_alarm_table #(
	parameter int unsigned ALARM_SLOTS = todat_pkg::DEF_ALARM_SLOTS
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  todat_pkg::in_t  in_data,
	output logic            out_valid,
	input  logic            out_ready,
	output todat_pkg::out_t out_data,
	input  logic            cfg_we,
	input  logic [1:0]      cfg_index,
	input  logic [31:0]     cfg_data
);
	import todat_pkg::*;

	localparam int CW = $clog2(ALARM_SLOTS + 1);
	localparam int AW = (ALARM_SLOTS > 1) ? $clog2(ALARM_SLOTS) : 1;
	localparam logic [CW-1:0] SLOTS_C = CW'(ALARM_SLOTS);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ADV,
		ST_SCAN,
		ST_FINISH,
		ST_RESP
	} state_t;

	state_t      state_q;
	logic [31:0] rate_q;
	logic [20:0] day_start_q;
	logic [20:0] night_start_q;
	logic [20:0] clock_q;
	logic [20:0] old_q;
	logic        wrap_q;
	logic [CW-1:0] count_q;
	logic [CW-1:0] rd_idx_q;
	logic [CW-1:0] keep_q;
	logic        s1_valid_q;
	logic        pend_q;
	logic [15:0] pend_id_q;
	logic        full_q;
	logic        out_valid_q;
	out_t        out_data_q;

	entry_t      mem [ALARM_SLOTS];
	entry_t      rd_data_q;

	adv_req_t    adv_req;
	adv_rsp_t    adv_rsp;

	logic        in_xfer;
	logic        out_free;
	logic        out_load;
	logic        is_day;
	logic        fire;
	logic        consume;
	logic        issue;
	logic        add_go;
	logic        keep_go;
	logic        wr_en;
	logic [AW-1:0] wr_addr;
	entry_t      wr_data;
	entry_t      new_entry;
	logic [20:0] set_hour;

	// Build one result item from the current clock
	function automatic out_t make_result(logic valid, logic [15:0] id, logic [20:0] clk_h,
			logic day, logic full, logic lst);
		out_t r;
		r.fired_valid = valid;
		r.fired_id    = id;
		r.clock_hour  = clk_h;
		r.is_day      = day;
		r.table_full  = full;
		r.last        = lst;
		return r;
	endfunction

	assign in_ready  = (state_q == ST_IDLE);
	assign in_xfer   = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;
	assign out_free  = !out_valid_q || out_ready;
	assign is_day    = (clock_q >= day_start_q) && (clock_q < night_start_q);

	// Saturate the alarm hour, reduce a set hour modulo one day
	always_comb begin
		new_entry.id   = in_data.alarm_id;
		new_entry.hour = (in_data.hour_value > DAY_UNITS_22) ? DAY_UNITS_21
		                                                     : in_data.hour_value[20:0];
		new_entry.rep  = in_data.repeat_flag;
		if (in_data.hour_value >= TWO_DAYS_22) begin
			set_hour = 21'(in_data.hour_value - TWO_DAYS_22);
		end else if (in_data.hour_value >= DAY_UNITS_22) begin
			set_hour = 21'(in_data.hour_value - DAY_UNITS_22);
		end else begin
			set_hour = in_data.hour_value[20:0];
		end
	end

	// Fire test on the slot held in the read register
	always_comb begin
		if (wrap_q) begin
			fire = (rd_data_q.hour > old_q) || (rd_data_q.hour <= clock_q);
		end else begin
			fire = (rd_data_q.hour > old_q) && (rd_data_q.hour <= clock_q);
		end
	end

	// Scan control: retire the held slot, issue the next read
	assign consume = (state_q == ST_SCAN) && s1_valid_q && (!fire || !pend_q || out_free);
	assign issue   = (state_q == ST_SCAN) && (rd_idx_q < count_q) && (!s1_valid_q || consume);
	assign keep_go = consume && (!fire || rd_data_q.rep);
	assign add_go  = in_xfer && (in_data.action == ACT_ADD) && (count_q < SLOTS_C);

	// Output register is loaded this cycle
	assign out_load = (consume && fire && pend_q) ||
	                  (((state_q == ST_FINISH) || (state_q == ST_RESP)) && out_free);

	// Single write port: append on add, compact during the scan
	always_comb begin
		wr_en   = add_go || keep_go;
		wr_addr = add_go ? count_q[AW-1:0] : keep_q[AW-1:0];
		wr_data = add_go ? new_entry : rd_data_q;
	end

	// Advance request at the tick transfer
	always_comb begin
		adv_req.start     = in_xfer && (in_data.action == ACT_TICK);
		adv_req.old_clock = clock_q;
		adv_req.elapsed   = in_data.elapsed_ms;
		adv_req.rate      = rate_q;
	end

	todat_advance u_advance (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (adv_req),
		.rsp    (adv_rsp)
	);

	// Alarm table memory, registered read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (issue) begin
			rd_data_q <= mem[rd_idx_q[AW-1:0]];
		end
	end

	// Sequencer, state and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			rate_q        <= DEFAULT_RATE;
			day_start_q   <= DAY_START_RST;
			night_start_q <= NIGHT_START_RST;
			clock_q       <= 21'd0;
			old_q         <= 21'd0;
			wrap_q        <= 1'b0;
			count_q       <= '0;
			rd_idx_q      <= '0;
			keep_q        <= '0;
			s1_valid_q    <= 1'b0;
			pend_q        <= 1'b0;
			pend_id_q     <= '0;
			full_q        <= 1'b0;
			out_valid_q   <= 1'b0;
			out_data_q    <= '0;
		end else begin
			// Register writes
			if (cfg_we) begin
				case (cfg_index)
					CFG_RATE:        rate_q        <= cfg_data;
					CFG_DAY_START:   day_start_q   <= cfg_data[20:0];
					CFG_NIGHT_START: night_start_q <= cfg_data[20:0];
					default: ;
				endcase
			end

			// Drop a result once transferred unless a new one replaces it
			if (out_valid_q && out_ready && !out_load) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						full_q <= (in_data.action == ACT_ADD) && (count_q >= SLOTS_C);
						case (in_data.action)
							ACT_TICK: begin
								old_q   <= clock_q;
								state_q <= ST_ADV;
							end
							ACT_ADD: begin
								if (count_q < SLOTS_C) begin
									count_q <= count_q + 1'b1;
								end
								state_q <= ST_RESP;
							end
							ACT_SET: begin
								clock_q <= set_hour;
								state_q <= ST_RESP;
							end
							default: begin
								state_q <= ST_RESP;
							end
						endcase
					end
				end

				ST_ADV: begin
					if (adv_rsp.done) begin
						clock_q    <= adv_rsp.new_clock;
						wrap_q     <= adv_rsp.wrap;
						rd_idx_q   <= '0;
						keep_q     <= '0;
						s1_valid_q <= 1'b0;
						pend_q     <= 1'b0;
						state_q    <= ST_SCAN;
					end
				end

				ST_SCAN: begin
					if (!s1_valid_q && (rd_idx_q == count_q)) begin
						state_q <= ST_FINISH;
					end else begin
						// Advance the read pointer
						if (issue) begin
							rd_idx_q   <= rd_idx_q + 1'b1;
							s1_valid_q <= 1'b1;
						end else if (consume) begin
							s1_valid_q <= 1'b0;
						end
						// Retire the held slot
						if (consume) begin
							if (keep_go) begin
								keep_q <= keep_q + 1'b1;
							end
							if (fire) begin
								if (pend_q) begin
									out_valid_q <= 1'b1;
									out_data_q  <= make_result(1'b1, pend_id_q, clock_q,
									                           is_day, 1'b0, 1'b0);
								end
								pend_q    <= 1'b1;
								pend_id_q <= rd_data_q.id;
							end
						end
					end
				end

				ST_FINISH: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						out_data_q  <= make_result(pend_q, pend_q ? pend_id_q : 16'd0,
						                           clock_q, is_day, 1'b0, 1'b1);
						count_q     <= keep_q;
						state_q     <= ST_IDLE;
					end
				end

				ST_RESP: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						out_data_q  <= make_result(1'b0, 16'd0, clock_q, is_day,
						                           full_q, 1'b1);
						state_q     <= ST_IDLE;
					end
				end

				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Table never holds more alarms than it has slots
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= SLOTS_C)
		else $error("alarm count beyond table size");

	// Compaction never writes ahead of the read pointer
	a_keep_behind: assert property (@(posedge clk) disable iff (!arst_n)
		keep_q <= rd_idx_q)
		else $error("compaction write ahead of scan read");

	// Advance result arrives only while waiting for it
	a_adv_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		adv_rsp.done |-> (state_q == ST_ADV))
		else $error("advance result outside wait state");

	// A transfer in closes the input until its results are placed
	a_busy_after_xfer: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer |=> !in_ready)
		else $error("input ready right after a transfer");

	// No slot is held once the scan is over
	a_idle_no_slot: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> !s1_valid_q)
		else $error("slot left in read stage at idle");

endmodule
